// ===== design/asc_pkg.sv =====
// Shared types and helper functions for the Ascon-128a encryption engine.
// Holds the sponge state type, round constants and byte mask helpers.
// No dependencies.
`default_nettype none

package asc_pkg;

   typedef logic [4:0][63:0] sponge_type;

   localparam logic [63:0] IV_128A = 64'h80800c0800000000;
   localparam logic [3:0] LAST_ROUND = 4'd11;
   localparam logic [3:0] FIRST_ROUND_12 = 4'd0;
   localparam logic [3:0] FIRST_ROUND_8 = 4'd4;
   localparam logic [4:0] BLOCK_BYTES = 5'd16;

   function automatic logic [63:0] round_const(input logic [3:0] r);
      logic [3:0] hi_nib;
      hi_nib = 4'hf - r;
      return {56'd0, hi_nib, r};
   endfunction

   function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
      return (x >> n) | (x << (64 - n));
   endfunction

   // Mask of the first n big-endian bytes of a word.
   function automatic logic [63:0] lead_mask(input logic [2:0] n);
      logic [3:0] keep_bytes;
      logic [3:0] drop_bytes;
      keep_bytes = {1'b0, n};
      drop_bytes = 4'd8 - keep_bytes;
      if (n == 3'd0) begin
         return 64'd0;
      end
      return {64{1'b1}} << {drop_bytes, 3'b000};
   endfunction

   // Padding bit placed right after n big-endian bytes of a word.
   function automatic logic [63:0] pad_bit(input logic [2:0] n);
      return 64'h80 << (6'd56 - {n, 3'b000});
   endfunction

endpackage

`default_nettype wire

// ===== design/asc_round.sv =====
// One round of the Ascon permutation: constant addition, S-box layer and
// linear diffusion layer. Uses asc_pkg for the state type and constants.
`default_nettype none

module asc_round
   import asc_pkg::*;
(
   input  sponge_type  state_in,
   input  logic [3:0]  round_idx,
   output sponge_type  state_out
);

   always_comb begin
      logic [63:0] x0, x1, x2, x3, x4;
      logic [63:0] t0, t1, t2, t3, t4;
      x0 = state_in[0];
      x1 = state_in[1];
      x2 = state_in[2] ^ round_const(round_idx);
      x3 = state_in[3];
      x4 = state_in[4];
      x0 = x0 ^ x4;
      x4 = x4 ^ x3;
      x2 = x2 ^ x1;
      t0 = ~x0 & x1;
      t1 = ~x1 & x2;
      t2 = ~x2 & x3;
      t3 = ~x3 & x4;
      t4 = ~x4 & x0;
      x0 = x0 ^ t1;
      x1 = x1 ^ t2;
      x2 = x2 ^ t3;
      x3 = x3 ^ t4;
      x4 = x4 ^ t0;
      x1 = x1 ^ x0;
      x0 = x0 ^ x4;
      x3 = x3 ^ x2;
      x2 = ~x2;
      state_out[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
      state_out[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
      state_out[2] = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
      state_out[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
      state_out[4] = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
   end

endmodule

`default_nettype wire

// ===== design/ascon_aead_encryptor.sv =====
// Ascon-128a encryption engine: sequencer, sponge state, key and result registers.
// Depends on asc_pkg and asc_round (one permutation round per cycle).
//
//  channel | direction | tdata                                       | tuser   | tlast
//  req_    | in        | block_high, block_low, valid_bytes          | command | last_block
//  rsp_    | out       | out_high, out_low, out_bytes                | out_kind| last_of_run
//  csr_    | in        | csr_wdata is key_high (index 0) or key_low (index 1)
//
// Start, associated-data and plaintext blocks each run their permutation rounds through
// the single round unit, and a new request is taken only in the idle state.
// Reset is synchronous; it clears the sequencer, the phase, the key and the result valid flag.
// A held result stalls the sequencer only when it has a new result to load.
`default_nettype none

module ascon_aead_encryptor
   import asc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [135:0]  req_tdata,   // block_high[63:0], block_low[127:64], valid_bytes[132:128]
   input  logic [1:0]    req_tuser,   // command
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [135:0]  rsp_tdata,   // out_high[63:0], out_low[127:64], out_bytes[132:128]
   output logic [1:0]    rsp_tuser,   // out_kind
   output logic          rsp_tlast,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [63:0]   csr_wdata
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_PERM      = 4'd1;
   localparam logic [3:0] ST_INIT_DONE = 4'd2;
   localparam logic [3:0] ST_AD_PAD    = 4'd3;
   localparam logic [3:0] ST_AD_END    = 4'd4;
   localparam logic [3:0] ST_PT_OUT    = 4'd5;
   localparam logic [3:0] ST_PT_PAD0   = 4'd6;
   localparam logic [3:0] ST_FINAL     = 4'd7;
   localparam logic [3:0] ST_TAG       = 4'd8;
   localparam logic [3:0] ST_ERR       = 4'd9;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_READY = 2'd1;
   localparam logic [1:0] PH_AD    = 2'd2;
   localparam logic [1:0] PH_PT    = 2'd3;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_AD    = 2'd1;
   localparam logic [1:0] CMD_PT    = 2'd2;

   localparam logic [1:0] KIND_CT  = 2'd0;
   localparam logic [1:0] KIND_TAG = 2'd1;
   localparam logic [1:0] KIND_ERR = 2'd2;

   localparam logic       REG_KEY_HIGH = 1'b0;

   logic [3:0]   state_ff, state_in;
   logic [3:0]   after_ff, after_in;
   logic [3:0]   rc_ff, rc_in;
   logic [1:0]   phase_ff, phase_in;
   sponge_type   s_ff, s_in;
   sponge_type   s_round;
   logic [63:0]  hi_ff, hi_in;
   logic [63:0]  lo_ff, lo_in;
   logic [4:0]   vb_ff, vb_in;
   logic         last_ff, last_in;
   logic [63:0]  kh_ff, kl_ff;
   logic         ov_ff, ov_in;
   logic [63:0]  oh_ff, oh_in;
   logic [63:0]  ol_ff, ol_in;
   logic [4:0]   ob_ff, ob_in;
   logic [1:0]   ok_ff, ok_in;
   logic         olast_ff, olast_in;

   logic         out_free;
   logic [4:0]   req_vb;
   logic [63:0]  req_hi, req_lo;
   logic [63:0]  pad_s0, pad_s1, pad_oh, pad_ol;
   logic [63:0]  full_s0, full_s1;

   asc_round u_round (
      .state_in  (s_ff),
      .round_idx (rc_ff),
      .state_out (s_round)
   );

   assign req_hi = req_tdata[63:0];
   assign req_lo = req_tdata[127:64];
   assign req_vb = (req_tdata[132:128] > BLOCK_BYTES) ? BLOCK_BYTES : req_tdata[132:128];

   assign out_free = !ov_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   assign full_s0 = s_ff[0] ^ hi_ff;
   assign full_s1 = s_ff[1] ^ lo_ff;

   // Absorb a partial block of vb_ff (below sixteen) bytes, then pad; also forms the masked output words.
   always_comb begin
      logic [63:0] m;
      logic [63:0] x0, x1;
      if (vb_ff[3]) begin
         m = lead_mask(vb_ff[2:0]);
         x0 = s_ff[0] ^ hi_ff;
         x1 = s_ff[1] ^ (lo_ff & m);
         pad_oh = x0;
         pad_ol = x1 & m;
         pad_s0 = x0;
         pad_s1 = x1 ^ pad_bit(vb_ff[2:0]);
      end else begin
         m = lead_mask(vb_ff[2:0]);
         x0 = s_ff[0] ^ (hi_ff & m);
         x1 = s_ff[1];
         pad_oh = x0 & m;
         pad_ol = 64'd0;
         pad_s0 = x0 ^ pad_bit(vb_ff[2:0]);
         pad_s1 = x1;
      end
   end

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      rc_in    = rc_ff;
      phase_in = phase_ff;
      s_in     = s_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      vb_in    = vb_ff;
      last_in  = last_ff;
      ov_in    = ov_ff;
      oh_in    = oh_ff;
      ol_in    = ol_ff;
      ob_in    = ob_ff;
      ok_in    = ok_ff;
      olast_in = olast_ff;
      if (ov_ff && rsp_tready) begin
         ov_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               hi_in   = req_hi;
               lo_in   = req_lo;
               vb_in   = req_vb;
               last_in = req_tlast;
               if (req_tuser == CMD_START) begin
                  s_in[0]  = IV_128A;
                  s_in[1]  = kh_ff;
                  s_in[2]  = kl_ff;
                  s_in[3]  = req_hi;
                  s_in[4]  = req_lo;
                  rc_in    = FIRST_ROUND_12;
                  after_in = ST_INIT_DONE;
                  state_in = ST_PERM;
               end else if (req_tuser == CMD_AD &&
                            (phase_ff == PH_READY || phase_ff == PH_AD)) begin
                  if (!req_tlast) begin
                     s_in[0]  = s_ff[0] ^ req_hi;
                     s_in[1]  = s_ff[1] ^ req_lo;
                     rc_in    = FIRST_ROUND_8;
                     after_in = ST_IDLE;
                     phase_in = PH_AD;
                     state_in = ST_PERM;
                  end else if (phase_ff == PH_READY && req_vb == 5'd0) begin
                     s_in[4]  = s_ff[4] ^ 64'd1;
                     phase_in = PH_PT;
                  end else if (req_vb == BLOCK_BYTES) begin
                     s_in[0]  = s_ff[0] ^ req_hi;
                     s_in[1]  = s_ff[1] ^ req_lo;
                     vb_in    = 5'd0;
                     rc_in    = FIRST_ROUND_8;
                     after_in = ST_AD_PAD;
                     state_in = ST_PERM;
                  end else begin
                     state_in = ST_AD_PAD;
                  end
               end else if (req_tuser == CMD_PT &&
                            (phase_ff == PH_READY || phase_ff == PH_PT)) begin
                  if (phase_ff == PH_READY) begin
                     s_in[4]  = s_ff[4] ^ 64'd1;
                     phase_in = PH_PT;
                  end
                  state_in = ST_PT_OUT;
               end else begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_PERM: begin
            s_in = s_round;
            if (rc_ff == LAST_ROUND) begin
               state_in = after_ff;
            end else begin
               rc_in = rc_ff + 4'd1;
            end
         end
         ST_INIT_DONE: begin
            s_in[3]  = s_ff[3] ^ kh_ff;
            s_in[4]  = s_ff[4] ^ kl_ff;
            phase_in = PH_READY;
            state_in = ST_IDLE;
         end
         ST_AD_PAD: begin
            s_in[0]  = pad_s0;
            s_in[1]  = pad_s1;
            rc_in    = FIRST_ROUND_8;
            after_in = ST_AD_END;
            state_in = ST_PERM;
         end
         ST_AD_END: begin
            s_in[4]  = s_ff[4] ^ 64'd1;
            phase_in = PH_PT;
            state_in = ST_IDLE;
         end
         ST_PT_OUT: begin
            if (out_free) begin
               ov_in = 1'b1;
               ok_in = KIND_CT;
               if (!last_ff || vb_ff == BLOCK_BYTES) begin
                  s_in[0]  = full_s0;
                  s_in[1]  = full_s1;
                  oh_in    = full_s0;
                  ol_in    = full_s1;
                  ob_in    = BLOCK_BYTES;
                  olast_in = !last_ff;
                  rc_in    = FIRST_ROUND_8;
                  after_in = last_ff ? ST_PT_PAD0 : ST_IDLE;
                  vb_in    = 5'd0;
                  state_in = ST_PERM;
               end else begin
                  s_in[0]  = pad_s0;
                  s_in[1]  = pad_s1;
                  oh_in    = pad_oh;
                  ol_in    = pad_ol;
                  ob_in    = vb_ff;
                  olast_in = 1'b0;
                  state_in = ST_FINAL;
               end
            end
         end
         ST_PT_PAD0: begin
            s_in[0]  = pad_s0;
            s_in[1]  = pad_s1;
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            s_in[2]  = s_ff[2] ^ kh_ff;
            s_in[3]  = s_ff[3] ^ kl_ff;
            rc_in    = FIRST_ROUND_12;
            after_in = ST_TAG;
            state_in = ST_PERM;
         end
         ST_TAG: begin
            if (out_free) begin
               s_in[3]  = s_ff[3] ^ kh_ff;
               s_in[4]  = s_ff[4] ^ kl_ff;
               ov_in    = 1'b1;
               oh_in    = s_ff[3] ^ kh_ff;
               ol_in    = s_ff[4] ^ kl_ff;
               ob_in    = BLOCK_BYTES;
               ok_in    = KIND_TAG;
               olast_in = 1'b1;
               phase_in = PH_IDLE;
               state_in = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               ov_in    = 1'b1;
               oh_in    = 64'd0;
               ol_in    = 64'd0;
               ob_in    = 5'd0;
               ok_in    = KIND_ERR;
               olast_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
         ov_ff    <= 1'b0;
         kh_ff    <= 64'd0;
         kl_ff    <= 64'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         ov_ff    <= ov_in;
         if (csr_we) begin
            if (csr_index == REG_KEY_HIGH) begin
               kh_ff <= csr_wdata;
            end else begin
               kl_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      after_ff <= after_in;
      rc_ff    <= rc_in;
      s_ff     <= s_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      vb_ff    <= vb_in;
      last_ff  <= last_in;
      oh_ff    <= oh_in;
      ol_ff    <= ol_in;
      ob_ff    <= ob_in;
      ok_ff    <= ok_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {3'b000, ob_ff, ol_ff, oh_ff};
   assign rsp_tuser  = ok_ff;
   assign rsp_tlast  = olast_ff;

`ifndef SYNTHESIS
   a_start_runs_perm: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_START |=> state_ff == ST_PERM)
      else $error("start transaction did not enter the permutation");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PERM |-> rc_ff <= LAST_ROUND)
      else $error("round counter out of range");

   a_tag_in_pt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TAG |-> phase_ff == PH_PT)
      else $error("tag stage reached outside plaintext phase");

   a_tag_ends_msg: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TAG && out_free |=> phase_ff == PH_IDLE && rsp_tvalid
                                         && rsp_tuser == KIND_TAG)
      else $error("tag transaction did not close the message");
`endif

endmodule

`default_nettype wire
